// ----- rtl/dbcs_pkg.sv -----
// Shared widths and the command word passed from front to back.
package dbcs_pkg;

	localparam int ENTRIES_DEF   = 64;
	localparam int FRAC_BITS_DEF = 4;

	localparam int SLOT_W = 6;
	localparam int KIND_W = 4;
	localparam int POS_W  = 16;
	localparam int SIZE_W = 10;
	localparam int DIR_W  = 2;

	// fits pos + (size << 8) without wrap for any fraction width up to 8
	localparam int CRD_W = 20;

	// front-to-back queue depth
	localparam int Q_DEPTH = 2;

	typedef enum logic [DIR_W-1:0] {
		DIR_UP    = 2'd0,
		DIR_DOWN  = 2'd1,
		DIR_LEFT  = 2'd2,
		DIR_RIGHT = 2'd3
	} dir_t;

	typedef struct packed {
		logic                     is_query;
		logic [SLOT_W-1:0]        wr_slot;
		logic                     wr_used;
		logic [KIND_W-1:0]        wr_kind;
		logic signed [POS_W-1:0]  wr_x;
		logic signed [POS_W-1:0]  wr_y;
		logic [SIZE_W-1:0]        wr_w;
		logic [SIZE_W-1:0]        wr_h;
		logic [KIND_W-1:0]        skip_kind;
		logic [SLOT_W-1:0]        skip_slot;
		logic                     lead_on_x;
		logic signed [CRD_W-1:0]  lead;
		logic signed [CRD_W-1:0]  side0;
		logic signed [CRD_W-1:0]  side1;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

// ----- rtl/dbcs_front.sv -----
// Front end: takes input words and turns queries into probe edge coordinates.
module dbcs_front #(
	parameter int FRAC_BITS = dbcs_pkg::FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              mode,
	input  logic [dbcs_pkg::SLOT_W-1:0]       slot,
	input  logic                              entry_used,
	input  logic [dbcs_pkg::KIND_W-1:0]       entry_kind,
	input  logic signed [dbcs_pkg::POS_W-1:0] pos_x,
	input  logic signed [dbcs_pkg::POS_W-1:0] pos_y,
	input  logic [dbcs_pkg::SIZE_W-1:0]       size_w,
	input  logic [dbcs_pkg::SIZE_W-1:0]       size_h,
	input  logic [dbcs_pkg::KIND_W-1:0]       skip_kind,
	input  logic [dbcs_pkg::SLOT_W-1:0]       skip_slot,
	input  logic [dbcs_pkg::DIR_W-1:0]        direction,
	input  dbcs_pkg::q_stat_t                 q_stat,
	output logic                              push,
	output dbcs_pkg::cmd_t                    push_cmd
);
	import dbcs_pkg::*;

	logic                    vld_s1;
	cmd_t                    cmd_s1;
	cmd_t                    cmd_nx;
	logic                    accept;
	logic signed [CRD_W-1:0] one;
	logic signed [CRD_W-1:0] px, py, pw, ph, px_end, py_end, py_below;

	assign one      = signed'(CRD_W'(1) << FRAC_BITS);
	assign px       = {{(CRD_W-POS_W){pos_x[POS_W-1]}}, pos_x};
	assign py       = {{(CRD_W-POS_W){pos_y[POS_W-1]}}, pos_y};
	assign pw       = signed'(CRD_W'(size_w) << FRAC_BITS);
	assign ph       = signed'(CRD_W'(size_h) << FRAC_BITS);
	assign px_end   = px + pw - one;
	assign py_end   = py + ph - one;
	// down edge sits one pixel past the box bottom
	assign py_below = py + ph;

	always_comb begin
		cmd_nx           = '0;
		cmd_nx.is_query  = mode;
		cmd_nx.wr_slot   = slot;
		cmd_nx.wr_used   = entry_used;
		cmd_nx.wr_kind   = entry_kind;
		cmd_nx.wr_x      = pos_x;
		cmd_nx.wr_y      = pos_y;
		cmd_nx.wr_w      = size_w;
		cmd_nx.wr_h      = size_h;
		cmd_nx.skip_kind = skip_kind;
		cmd_nx.skip_slot = skip_slot;
		unique case (dir_t'(direction))
			DIR_UP: begin
				cmd_nx.lead_on_x = 1'b0;
				cmd_nx.lead      = py;
				cmd_nx.side0     = px;
				cmd_nx.side1     = px_end;
			end
			DIR_DOWN: begin
				cmd_nx.lead_on_x = 1'b0;
				cmd_nx.lead      = py_below;
				cmd_nx.side0     = px;
				cmd_nx.side1     = px_end;
			end
			DIR_LEFT: begin
				cmd_nx.lead_on_x = 1'b1;
				cmd_nx.lead      = px;
				cmd_nx.side0     = py;
				cmd_nx.side1     = py_end;
			end
			DIR_RIGHT: begin
				cmd_nx.lead_on_x = 1'b1;
				cmd_nx.lead      = px_end;
				cmd_nx.side0     = py;
				cmd_nx.side1     = py_end;
			end
			default: begin
				cmd_nx.lead_on_x = 1'b0;
				cmd_nx.lead      = py;
				cmd_nx.side0     = px;
				cmd_nx.side1     = px_end;
			end
		endcase
	end

	assign push     = vld_s1 && !q_stat.full;
	assign in_stall = vld_s1 && q_stat.full;
	assign accept   = in_valid && !in_stall;
	assign push_cmd = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (accept) begin
			vld_s1 <= 1'b1;
		end else if (push) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= cmd_nx;
		end
	end

endmodule

// ----- rtl/dbcs_fifo.sv -----
// Short command queue between the front end and the scan engine.
module dbcs_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  dbcs_pkg::cmd_t    push_cmd,
	input  logic              pop,
	output dbcs_pkg::cmd_t    pop_cmd,
	output dbcs_pkg::q_stat_t q_stat
);
	import dbcs_pkg::*;

	localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int CNT_W = $clog2(Q_DEPTH + 1);

	cmd_t             buf_q [Q_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push, do_pop;

	assign q_stat.full  = (cnt_q == CNT_W'(Q_DEPTH));
	assign q_stat.empty = (cnt_q == '0);
	assign do_push      = push && !q_stat.full;
	assign do_pop       = pop && !q_stat.empty;
	assign pop_cmd      = buf_q[rd_ptr_q];

	function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(Q_DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= bump(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= bump(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			buf_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

// ----- rtl/dbcs_back.sv -----
// Scan engine: box table memory, slot-by-slot compare pipeline, result register.
module dbcs_back #(
	parameter int ENTRIES   = dbcs_pkg::ENTRIES_DEF,
	parameter int FRAC_BITS = dbcs_pkg::FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  dbcs_pkg::q_stat_t                 q_stat,
	input  dbcs_pkg::cmd_t                    pop_cmd,
	output logic                              pop,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              hit,
	output logic [dbcs_pkg::SLOT_W-1:0]       hit_slot,
	output logic signed [dbcs_pkg::POS_W-1:0] hit_x,
	output logic signed [dbcs_pkg::POS_W-1:0] hit_y
);
	import dbcs_pkg::*;

	// only the first 2**SLOT_W slots can ever be written
	localparam int TBL_N = (ENTRIES < (1 << SLOT_W)) ? ENTRIES : (1 << SLOT_W);
	localparam int IDX_W = $clog2(TBL_N);
	localparam logic [POS_W-1:0] MISS_POS = POS_W'(-(100 <<< FRAC_BITS));

	typedef struct packed {
		logic [KIND_W-1:0]       kind;
		logic signed [POS_W-1:0] x;
		logic signed [POS_W-1:0] y;
		logic [SIZE_W-1:0]       w;
		logic [SIZE_W-1:0]       h;
	} ent_t;

	typedef enum logic {
		B_IDLE,
		B_SCAN
	} bstate_t;

	bstate_t          state_q;
	cmd_t             qry_q;
	logic [IDX_W-1:0] iss_idx_q;
	logic             iss_on_q;

	ent_t             mem [TBL_N];
	logic [TBL_N-1:0] used_q;

	logic             vld_s1, used_s1;
	logic [IDX_W-1:0] idx_s1;
	ent_t             ent_s1;

	logic                    vld_s2, ok_s2, last_s2;
	logic [IDX_W-1:0]        idx_s2;
	logic signed [CRD_W-1:0] cx_s2, cy_s2, cxe_s2, cye_s2;

	logic                    out_valid_q, hit_q;
	logic [SLOT_W-1:0]       hit_slot_q;
	logic [POS_W-1:0]        hit_x_q, hit_y_q;

	logic                    out_free, wr_en, slot_ok, wr_done, qry_start;
	logic signed [CRD_W-1:0] cx_s1, cy_s1;
	logic signed [CRD_W-1:0] lead, side0, side1, a_lo, a_hi, b_lo, b_hi;
	logic                    lead_in, side_in, found, finish;

	assign out_free  = !out_valid_q || !out_stall;
	assign pop       = (state_q == B_IDLE) && !q_stat.empty && out_free;
	assign slot_ok   = (pop_cmd.wr_slot < SLOT_W'(TBL_N)) || (TBL_N == (1 << SLOT_W));
	assign wr_en     = pop && !pop_cmd.is_query && slot_ok;
	assign wr_done   = pop && !pop_cmd.is_query;
	assign qry_start = pop && pop_cmd.is_query;

	// table memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[pop_cmd.wr_slot[IDX_W-1:0]] <= '{kind: pop_cmd.wr_kind, x: pop_cmd.wr_x,
				y: pop_cmd.wr_y, w: pop_cmd.wr_w, h: pop_cmd.wr_h};
		end
		if (iss_on_q) begin
			ent_s1 <= mem[iss_idx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
		end else if (wr_en) begin
			used_q[pop_cmd.wr_slot[IDX_W-1:0]] <= pop_cmd.wr_used;
		end
	end

	// stage 2: box edges and skip checks
	assign cx_s1 = {{(CRD_W-POS_W){ent_s1.x[POS_W-1]}}, ent_s1.x};
	assign cy_s1 = {{(CRD_W-POS_W){ent_s1.y[POS_W-1]}}, ent_s1.y};

	always_ff @(posedge clk) begin
		if (iss_on_q) begin
			idx_s1  <= iss_idx_q;
			used_s1 <= used_q[iss_idx_q];
		end
		if (vld_s1) begin
			idx_s2  <= idx_s1;
			last_s2 <= (idx_s1 == IDX_W'(TBL_N - 1));
			ok_s2   <= used_s1 && (ent_s1.kind != qry_q.skip_kind) &&
				(SLOT_W'(idx_s1) != qry_q.skip_slot);
			cx_s2   <= cx_s1;
			cy_s2   <= cy_s1;
			cxe_s2  <= cx_s1 + signed'(CRD_W'(ent_s1.w) << FRAC_BITS);
			cye_s2  <= cy_s1 + signed'(CRD_W'(ent_s1.h) << FRAC_BITS);
		end
	end

	// stage 3: span tests against the probe edge
	assign lead  = qry_q.lead;
	assign side0 = qry_q.side0;
	assign side1 = qry_q.side1;
	assign a_lo  = qry_q.lead_on_x ? cx_s2  : cy_s2;
	assign a_hi  = qry_q.lead_on_x ? cxe_s2 : cye_s2;
	assign b_lo  = qry_q.lead_on_x ? cy_s2  : cx_s2;
	assign b_hi  = qry_q.lead_on_x ? cye_s2 : cxe_s2;

	assign lead_in = (lead >= a_lo) && (lead < a_hi);
	assign side_in = ((side0 >= b_lo) && (side0 < b_hi)) ||
		((side1 >= b_lo) && (side1 < b_hi));
	assign found   = vld_s2 && ok_s2 && lead_in && side_in;
	assign finish  = vld_s2 && (found || last_s2);

	always_ff @(posedge clk) begin
		if (qry_start) begin
			qry_q <= pop_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			iss_idx_q   <= '0;
			iss_on_q    <= 1'b0;
			vld_s1      <= 1'b0;
			vld_s2      <= 1'b0;
			out_valid_q <= 1'b0;
			hit_q       <= 1'b0;
			hit_slot_q  <= '0;
			hit_x_q     <= '0;
			hit_y_q     <= '0;
		end else begin
			unique case (state_q)
				B_IDLE: begin
					if (qry_start) begin
						state_q <= B_SCAN;
					end
				end
				B_SCAN: begin
					if (finish) begin
						state_q <= B_IDLE;
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase

			if (qry_start) begin
				iss_idx_q <= '0;
				iss_on_q  <= 1'b1;
			end else if (finish) begin
				iss_on_q <= 1'b0;
			end else if (iss_on_q) begin
				iss_idx_q <= iss_idx_q + IDX_W'(1);
				iss_on_q  <= (iss_idx_q != IDX_W'(TBL_N - 1));
			end

			// later slots still in flight are dropped
			if (finish) begin
				vld_s1 <= 1'b0;
				vld_s2 <= 1'b0;
			end else begin
				vld_s1 <= iss_on_q;
				vld_s2 <= vld_s1;
			end

			if (wr_done) begin
				// write word: all-zero result
				out_valid_q <= 1'b1;
				hit_q       <= 1'b0;
				hit_slot_q  <= '0;
				hit_x_q     <= '0;
				hit_y_q     <= '0;
			end else if (finish) begin
				out_valid_q <= 1'b1;
				hit_q       <= found;
				hit_slot_q  <= found ? SLOT_W'(idx_s2) : '0;
				hit_x_q     <= found ? cx_s2[POS_W-1:0] : MISS_POS;
				hit_y_q     <= found ? cy_s2[POS_W-1:0] : MISS_POS;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign hit       = hit_q;
	assign hit_slot  = hit_slot_q;
	assign hit_x     = signed'(hit_x_q);
	assign hit_y     = signed'(hit_y_q);

endmodule

// ----- rtl/directional_box_collision_scan.sv -----
// Top level: box table collision scan, front end, command queue and scan engine.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-----------------------------------------------
//  in      | in  | in_valid/in_stall  | mode slot entry_used entry_kind pos_x pos_y
//          |     |                    | size_w size_h skip_kind skip_slot direction
//  out     | out | out_valid/out_stall| hit hit_slot hit_x hit_y
//
//  A write word passes the front-end register and the queue into the result register.
//  A query reads one table slot per cycle through the table memory's single read
//  port; a hit ends the scan at the first matching slot, a miss only after all N
//  slots, with N = min(ENTRIES, 64).
//  Reset clears the used flags at once; no clearing pass is needed.
//  A stalled result holds the scan engine; the queue keeps taking input until full.
module directional_box_collision_scan #(
	parameter int ENTRIES   = dbcs_pkg::ENTRIES_DEF,
	parameter int FRAC_BITS = dbcs_pkg::FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              mode,
	input  logic [dbcs_pkg::SLOT_W-1:0]       slot,
	input  logic                              entry_used,
	input  logic [dbcs_pkg::KIND_W-1:0]       entry_kind,
	input  logic signed [dbcs_pkg::POS_W-1:0] pos_x,
	input  logic signed [dbcs_pkg::POS_W-1:0] pos_y,
	input  logic [dbcs_pkg::SIZE_W-1:0]       size_w,
	input  logic [dbcs_pkg::SIZE_W-1:0]       size_h,
	input  logic [dbcs_pkg::KIND_W-1:0]       skip_kind,
	input  logic [dbcs_pkg::SLOT_W-1:0]       skip_slot,
	input  logic [dbcs_pkg::DIR_W-1:0]        direction,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              hit,
	output logic [dbcs_pkg::SLOT_W-1:0]       hit_slot,
	output logic signed [dbcs_pkg::POS_W-1:0] hit_x,
	output logic signed [dbcs_pkg::POS_W-1:0] hit_y
);
	import dbcs_pkg::*;

	q_stat_t q_stat;
	logic    push, pop;
	cmd_t    push_cmd, pop_cmd;

	dbcs_front #(
		.FRAC_BITS(FRAC_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.mode       (mode),
		.slot       (slot),
		.entry_used (entry_used),
		.entry_kind (entry_kind),
		.pos_x      (pos_x),
		.pos_y      (pos_y),
		.size_w     (size_w),
		.size_h     (size_h),
		.skip_kind  (skip_kind),
		.skip_slot  (skip_slot),
		.direction  (direction),
		.q_stat     (q_stat),
		.push       (push),
		.push_cmd   (push_cmd)
	);

	dbcs_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.pop_cmd  (pop_cmd),
		.q_stat   (q_stat)
	);

	dbcs_back #(
		.ENTRIES   (ENTRIES),
		.FRAC_BITS (FRAC_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_stat    (q_stat),
		.pop_cmd   (pop_cmd),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.hit       (hit),
		.hit_slot  (hit_slot),
		.hit_x     (hit_x),
		.hit_y     (hit_y)
	);

endmodule

// ----- rtl/dbcs_check.sv -----
// Port-level checks for the collision scan, bound to the top level.
module dbcs_check #(
	parameter int FRAC_BITS = dbcs_pkg::FRAC_BITS_DEF
) (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              out_valid,
	input logic                              out_stall,
	input logic                              hit,
	input logic [dbcs_pkg::SLOT_W-1:0]       hit_slot,
	input logic signed [dbcs_pkg::POS_W-1:0] hit_x,
	input logic signed [dbcs_pkg::POS_W-1:0] hit_y
);
	import dbcs_pkg::*;

	localparam logic [POS_W-1:0] MISS_POS = POS_W'(-(100 <<< FRAC_BITS));

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result word dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(hit) && $stable(hit_slot) &&
			$stable(hit_x) && $stable(hit_y))
		else $error("stalled result word changed");

	a_miss_slot: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !hit |-> hit_slot == '0)
		else $error("miss or write word carries a slot");

	a_miss_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !hit |-> (hit_x == '0 && hit_y == '0) ||
			(hit_x == MISS_POS && hit_y == MISS_POS))
		else $error("miss or write word carries a bad position");

endmodule

bind directional_box_collision_scan dbcs_check #(
	.FRAC_BITS(FRAC_BITS)
) u_dbcs_check (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.hit       (hit),
	.hit_slot  (hit_slot),
	.hit_x     (hit_x),
	.hit_y     (hit_y)
);
